[rtl/cau_pkg.sv]
// Shared constants, types and helpers for the complex arithmetic unit.
package cau_pkg;

   // number format
   localparam int DATA_W = 32;
   localparam int FRAC_W = 16;

   // derived widths
   localparam int PROD_W = 2 * DATA_W;          // one product, or a squared norm
   localparam int SUM_W  = PROD_W + 1;          // sum or difference of two products
   localparam int NUM_W  = PROD_W + FRAC_W;     // magnitude of a scaled dividend
   localparam int WIDE_W = NUM_W + 1;           // signed value ahead of clamping
   localparam int ROOT_W = PROD_W / 2;          // square root of a norm
   localparam int SREM_W = ROOT_W + 2;          // square root remainder
   localparam int CNT_W  = $clog2(NUM_W + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // opcodes
   localparam logic [2:0] OP_ADD  = 3'd0;
   localparam logic [2:0] OP_SUB  = 3'd1;
   localparam logic [2:0] OP_MUL  = 3'd2;
   localparam logic [2:0] OP_DIV  = 3'd3;
   localparam logic [2:0] OP_CONJ = 3'd4;
   localparam logic [2:0] OP_MOD  = 3'd5;

   // classified word passed from the front end to the back end
   typedef struct packed {
      logic [2:0]               op;
      logic signed [SUM_W-1:0]  x;   // real-side operand or dividend
      logic signed [SUM_W-1:0]  y;   // imaginary-side operand or dividend
      logic [PROD_W-1:0]        d;   // divisor norm or modulus radicand
   } cau_entry_type;

   // clamp a wide signed value to the data range: {flag, value}
   function automatic logic [DATA_W:0] cau_sat(input logic signed [WIDE_W-1:0] v);
      logic [WIDE_W-DATA_W:0] top;
      logic [DATA_W-1:0]      lim;
      top = v[WIDE_W-1:DATA_W-1];
      if ((top == '0) || (top == '1)) begin
         cau_sat = {1'b0, v[DATA_W-1:0]};
      end else begin
         lim = {v[WIDE_W-1], {(DATA_W-1){~v[WIDE_W-1]}}};
         cau_sat = {1'b1, lim};
      end
   endfunction

endpackage

[rtl/cau_if.sv]
// Request and response channel interfaces.
interface cau_req_if;
   import cau_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [2:0]               req_type;
   logic signed [DATA_W-1:0] a_re;
   logic signed [DATA_W-1:0] a_im;
   logic signed [DATA_W-1:0] b_re;
   logic signed [DATA_W-1:0] b_im;
   modport source (output valid, req_type, a_re, a_im, b_re, b_im, input ready);
   modport sink   (input valid, req_type, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if;
   import cau_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] res_re;
   logic signed [DATA_W-1:0] res_im;
   logic                     div_zero;
   logic                     saturated;
   modport source (output valid, res_re, res_im, div_zero, saturated, input ready);
   modport sink   (input valid, res_re, res_im, div_zero, saturated, output ready);
endinterface

[rtl/cau_front.sv]
// Front end: accepts requests, forms products and classifies each word.
module cau_front (
   input  logic                   clock,
   input  logic                   reset,
   cau_req_if.sink                req_chan,
   output logic                   push_valid,
   output cau_pkg::cau_entry_type push_data,
   input  logic                   push_ready
);
   import cau_pkg::*;

   logic                     st_valid_ff, st_valid_in;
   logic [2:0]               st_op_ff;
   logic signed [DATA_W-1:0] st_ar_ff, st_ai_ff, st_br_ff, st_bi_ff;
   logic signed [PROD_W-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [DATA_W-1:0] m4, m5;
   logic                     advance;

   assign advance        = !st_valid_ff || push_ready;
   assign req_chan.ready = advance;
   assign st_valid_in    = advance ? req_chan.valid : st_valid_ff;

   // squares of a for the modulus, of b for the divisor norm
   assign m4 = (req_chan.req_type == OP_MOD) ? req_chan.a_re : req_chan.b_re;
   assign m5 = (req_chan.req_type == OP_MOD) ? req_chan.a_im : req_chan.b_im;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
      end else begin
         st_valid_ff <= st_valid_in;
      end
   end

   // product stage
   always_ff @(posedge clock) begin
      if (advance) begin
         st_op_ff <= req_chan.req_type;
         st_ar_ff <= req_chan.a_re;
         st_ai_ff <= req_chan.a_im;
         st_br_ff <= req_chan.b_re;
         st_bi_ff <= req_chan.b_im;
         p0_ff    <= req_chan.a_re * req_chan.b_re;
         p1_ff    <= req_chan.a_im * req_chan.b_im;
         p2_ff    <= req_chan.a_re * req_chan.b_im;
         p3_ff    <= req_chan.a_im * req_chan.b_re;
         p4_ff    <= m4 * m4;
         p5_ff    <= m5 * m5;
      end
   end

   // classify: combine products into the operands the back end needs
   always_comb begin
      push_data.op = st_op_ff;
      push_data.x  = '0;
      push_data.y  = '0;
      push_data.d  = PROD_W'(p4_ff) + PROD_W'(p5_ff);
      unique case (st_op_ff)
         OP_ADD: begin
            push_data.x = SUM_W'(st_ar_ff) + SUM_W'(st_br_ff);
            push_data.y = SUM_W'(st_ai_ff) + SUM_W'(st_bi_ff);
         end
         OP_SUB: begin
            push_data.x = SUM_W'(st_ar_ff) - SUM_W'(st_br_ff);
            push_data.y = SUM_W'(st_ai_ff) - SUM_W'(st_bi_ff);
         end
         OP_MUL: begin
            push_data.x = SUM_W'(p0_ff) - SUM_W'(p1_ff);
            push_data.y = SUM_W'(p2_ff) + SUM_W'(p3_ff);
         end
         OP_DIV: begin
            push_data.x = SUM_W'(p0_ff) + SUM_W'(p1_ff);
            push_data.y = SUM_W'(p3_ff) - SUM_W'(p2_ff);
         end
         OP_CONJ: begin
            push_data.x = SUM_W'(st_ar_ff);
            push_data.y = -SUM_W'(st_ai_ff);
         end
         default: begin
         end
      endcase
   end

   assign push_valid = st_valid_ff;

endmodule

[rtl/cau_queue.sv]
// Short queue between the front end and the back end.
module cau_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  cau_pkg::cau_entry_type push_data,
   output logic                   push_ready,
   output logic                   pop_valid,
   output cau_pkg::cau_entry_type pop_data,
   input  logic                   pop_ready
);
   import cau_pkg::*;

   cau_entry_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop) count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

[rtl/cau_back.sv]
// Back end: finishes each word, with shared iterative divide and square root.
module cau_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   input  cau_pkg::cau_entry_type pop_data,
   output logic                   pop_ready,
   cau_rsp_if.source              rsp_chan
);
   import cau_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_SQRT = 2'd2;

   logic [1:0]               state_ff, state_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [NUM_W-1:0]         nx_ff, ny_ff, nx_in, ny_in;
   logic [PROD_W-1:0]        rx_ff, ry_ff, rx_in, ry_in, d_ff, d_in;
   logic                     negx_ff, negy_ff, negx_in, negy_in;
   logic [SREM_W-1:0]        srem_ff, srem_in;
   logic [ROOT_W-1:0]        root_ff, root_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]        res_re_ff, res_im_ff, res_re_in, res_im_in;
   logic                     dz_ff, sat_ff, dz_in, sat_in;

   logic                     out_free, needs_iter, emit_now, emit_end, start;
   logic                     dzero;
   logic signed [WIDE_W-1:0] wx, wy;
   logic [DATA_W:0]          sx, sy;
   logic [PROD_W:0]          rxs, rys;
   logic [SREM_W+1:0]        srs, strial;
   logic [PROD_W-1:0]        magx, magy;

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign dzero      = (pop_data.op == OP_DIV) && (pop_data.d == '0);
   assign needs_iter = ((pop_data.op == OP_DIV) && !dzero) || (pop_data.op == OP_MOD);
   assign pop_ready  = (state_ff == ST_IDLE) && (needs_iter || out_free);
   assign start      = pop_valid && pop_ready && needs_iter;
   assign emit_now   = pop_valid && pop_ready && !needs_iter;
   assign emit_end   = (state_ff != ST_IDLE) && (cnt_ff == '0) && out_free;

   assign magx = pop_data.x[SUM_W-1] ? PROD_W'(-pop_data.x) : PROD_W'(pop_data.x);
   assign magy = pop_data.y[SUM_W-1] ? PROD_W'(-pop_data.y) : PROD_W'(pop_data.y);

   // one restoring step for each quotient and one root digit
   assign rxs    = {rx_ff, nx_ff[NUM_W-1]};
   assign rys    = {ry_ff, ny_ff[NUM_W-1]};
   assign srs    = {srem_ff, nx_ff[NUM_W-1:NUM_W-2]};
   assign strial = {2'b00, root_ff, 2'b01};

   // result value ahead of clamping
   always_comb begin
      wx = '0;
      wy = '0;
      if (state_ff == ST_DIV) begin
         wx = negx_ff ? -$signed({1'b0, nx_ff}) : $signed({1'b0, nx_ff});
         wy = negy_ff ? -$signed({1'b0, ny_ff}) : $signed({1'b0, ny_ff});
      end else if (state_ff == ST_SQRT) begin
         wx = $signed(WIDE_W'(root_ff));
      end else begin
         unique case (pop_data.op)
            OP_ADD, OP_SUB, OP_CONJ: begin
               wx = WIDE_W'($signed(pop_data.x));
               wy = WIDE_W'($signed(pop_data.y));
            end
            OP_MUL: begin
               wx = WIDE_W'($signed(pop_data.x)) >>> FRAC_W;
               wy = WIDE_W'($signed(pop_data.y)) >>> FRAC_W;
            end
            default: begin
            end
         endcase
      end
   end

   assign sx = cau_sat(wx);
   assign sy = cau_sat(wy);

   // sequencer and iteration registers
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      nx_in    = nx_ff;
      ny_in    = ny_ff;
      rx_in    = rx_ff;
      ry_in    = ry_ff;
      d_in     = d_ff;
      negx_in  = negx_ff;
      negy_in  = negy_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      if (start) begin
         d_in    = pop_data.d;
         rx_in   = '0;
         ry_in   = '0;
         srem_in = '0;
         root_in = '0;
         negx_in = pop_data.x[SUM_W-1];
         negy_in = pop_data.y[SUM_W-1];
         if (pop_data.op == OP_DIV) begin
            state_in = ST_DIV;
            cnt_in   = CNT_W'(NUM_W);
            nx_in    = {magx, {FRAC_W{1'b0}}};
            ny_in    = {magy, {FRAC_W{1'b0}}};
         end else begin
            state_in = ST_SQRT;
            cnt_in   = CNT_W'(ROOT_W);
            nx_in    = {pop_data.d, {FRAC_W{1'b0}}};
         end
      end else if ((state_ff != ST_IDLE) && (cnt_ff != '0)) begin
         cnt_in = cnt_ff - 1'b1;
         if (state_ff == ST_DIV) begin
            if (rxs >= {1'b0, d_ff}) begin
               rx_in = PROD_W'(rxs - {1'b0, d_ff});
               nx_in = {nx_ff[NUM_W-2:0], 1'b1};
            end else begin
               rx_in = PROD_W'(rxs);
               nx_in = {nx_ff[NUM_W-2:0], 1'b0};
            end
            if (rys >= {1'b0, d_ff}) begin
               ry_in = PROD_W'(rys - {1'b0, d_ff});
               ny_in = {ny_ff[NUM_W-2:0], 1'b1};
            end else begin
               ry_in = PROD_W'(rys);
               ny_in = {ny_ff[NUM_W-2:0], 1'b0};
            end
         end else begin
            nx_in = {nx_ff[NUM_W-3:0], 2'b00};
            if (srs >= strial) begin
               srem_in = SREM_W'(srs - strial);
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               srem_in = SREM_W'(srs);
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
         end
      end else if (emit_end) begin
         state_in = ST_IDLE;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      res_re_in    = res_re_ff;
      res_im_in    = res_im_ff;
      dz_in        = dz_ff;
      sat_in       = sat_ff;
      if (emit_now || emit_end) begin
         rsp_valid_in = 1'b1;
         res_re_in    = sx[DATA_W-1:0];
         res_im_in    = sy[DATA_W-1:0];
         dz_in        = emit_now && dzero;
         sat_in       = sx[DATA_W] || sy[DATA_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nx_ff     <= nx_in;
      ny_ff     <= ny_in;
      rx_ff     <= rx_in;
      ry_ff     <= ry_in;
      d_ff      <= d_in;
      negx_ff   <= negx_in;
      negy_ff   <= negy_in;
      srem_ff   <= srem_in;
      root_ff   <= root_in;
      res_re_ff <= res_re_in;
      res_im_ff <= res_im_in;
      dz_ff     <= dz_in;
      sat_ff    <= sat_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.res_re    = res_re_ff;
   assign rsp_chan.res_im    = res_im_ff;
   assign rsp_chan.div_zero  = dz_ff;
   assign rsp_chan.saturated = sat_ff;

   // a zero divisor gives a clean zero word
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && dz_ff) |-> (res_re_ff == '0 && res_im_ff == '0 && !sat_ff))
      else $error("div_zero word carries a nonzero result");

   // the queue is only drained while the iterative unit is free
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready) |-> (state_ff == ST_IDLE))
      else $error("word taken while iteration in progress");

   // iteration count steps down by one each cycle
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && cnt_ff != '0) |=> (cnt_ff == $past(cnt_ff) - 1'b1))
      else $error("iteration counter skipped");

endmodule

[rtl/complex_arithmetic_unit.sv]
// Complex arithmetic unit top level: front end, queue and back end.
// Takes one request word per cycle while the queue has room and returns one
// response word per request, in order. Add, subtract, multiply and conjugate pass
// the product stage, the queue and the output register and sustain one word per
// cycle unless the response stalls. Divide runs a shared restoring divider one
// quotient bit per cycle and modulus a digit-by-digit square root, each occupying
// the back end; a four-word queue lets the front end accept while it iterates or
// the response stalls. There is no configuration and no clearing pass after reset.
module complex_arithmetic_unit (
   input  logic       clock,
   input  logic       reset,
   cau_req_if.sink    req_chan,
   cau_rsp_if.source  rsp_chan
);
   import cau_pkg::*;

   logic          f_valid, f_ready, q_valid, q_ready;
   cau_entry_type f_data, q_data;

   cau_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (f_valid),
      .push_data  (f_data),
      .push_ready (f_ready)
   );

   cau_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_data  (f_data),
      .push_ready (f_ready),
      .pop_valid  (q_valid),
      .pop_data   (q_data),
      .pop_ready  (q_ready)
   );

   cau_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (q_valid),
      .pop_data  (q_data),
      .pop_ready (q_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

[sim/tb_cau_pkg.sv]
`timescale 1ns / 1ps
// Types shared by the complex arithmetic unit testbench.
package tb_cau_pkg;
   import cau_pkg::*;

   // one expected response word
   typedef struct packed {
      logic signed [DATA_W-1:0] res_re;
      logic signed [DATA_W-1:0] res_im;
      logic                     div_zero;
      logic                     saturated;
   } cau_resp_type;

endpackage

[sim/tb_cau_if.sv]
`timescale 1ns / 1ps
// Testbench copies of the request and response channel interfaces are not needed;
// this file holds a small interface with a response hold signal, tied low here.
interface tb_cau_stall_if;
   logic hold_rsp;
   modport source (output hold_rsp);
   modport sink   (input hold_rsp);
endinterface

[sim/tb_complex_arithmetic_unit.sv]
`timescale 1ns / 1ps
// Testbench for the complex arithmetic unit: directed and random requests
// checked against a wide-integer predictor.
module tb_complex_arithmetic_unit;
   import cau_pkg::*;
   import tb_cau_pkg::*;

   localparam int  MAX_CYCLES = 400000;
   localparam int  DRAIN_CYCLES = 200;
   localparam logic [2:0] OP_SPARE6 = 3'd6;
   localparam logic [2:0] OP_SPARE7 = 3'd7;

   logic clock;
   logic reset;

   cau_req_if req_chan ();
   cau_rsp_if rsp_chan ();
   tb_cau_stall_if stall ();

   complex_arithmetic_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   cau_resp_type expected_words[$];
   int           mismatches;
   int           cycle_count;
   int           send_idle_pct;
   int           recv_idle_pct;
   int           long_hold;

   // clamp a wide signed value into the data range
   function automatic logic signed [DATA_W-1:0] clamp_part(input logic signed [191:0] v,
                                                          inout logic flag);
      logic signed [191:0] hi;
      logic signed [191:0] lo;
      hi = (192'sd1 <<< (DATA_W - 1)) - 1;
      lo = -(192'sd1 <<< (DATA_W - 1));
      if (v > hi) begin
         flag = 1'b1;
         return hi[DATA_W-1:0];
      end
      if (v < lo) begin
         flag = 1'b1;
         return lo[DATA_W-1:0];
      end
      return v[DATA_W-1:0];
   endfunction

   // floor square root of a non-negative value
   function automatic logic [191:0] floor_sqrt(input logic [191:0] n);
      logic [191:0] root;
      logic [191:0] trial;
      root = '0;
      for (int b = 95; b >= 0; b--) begin
         trial = root | (192'd1 << b);
         if (trial * trial <= n) root = trial;
      end
      return root;
   endfunction

   // signed quotient truncated toward zero, positive divisor
   function automatic logic signed [191:0] trunc_div(input logic signed [191:0] n,
                                                     input logic signed [191:0] d);
      logic [191:0] mag;
      mag = (n < 0) ? -n : n;
      mag = mag / d;
      return (n < 0) ? -$signed(mag) : $signed(mag);
   endfunction

   // predicted response for one request word
   function automatic cau_resp_type predict_complex(input logic [2:0] op,
                                                    input logic signed [DATA_W-1:0] ar,
                                                    input logic signed [DATA_W-1:0] ai,
                                                    input logic signed [DATA_W-1:0] br,
                                                    input logic signed [DATA_W-1:0] bi);
      logic signed [191:0] xr, xi, yr, yi, re, im, norm;
      logic                sat;
      cau_resp_type        r;
      xr = ar; xi = ai; yr = br; yi = bi;
      re = '0; im = '0; sat = 1'b0;
      r = '0;
      case (op)
         OP_ADD: begin
            re = xr + yr;
            im = xi + yi;
         end
         OP_SUB: begin
            re = xr - yr;
            im = xi - yi;
         end
         OP_MUL: begin
            re = (xr * yr - xi * yi) >>> FRAC_W;
            im = (xr * yi + xi * yr) >>> FRAC_W;
         end
         OP_DIV: begin
            norm = yr * yr + yi * yi;
            if (norm == 0) begin
               r.div_zero = 1'b1;
            end else begin
               re = trunc_div((xr * yr + xi * yi) <<< FRAC_W, norm);
               im = trunc_div((xi * yr - xr * yi) <<< FRAC_W, norm);
            end
         end
         OP_CONJ: begin
            re = xr;
            im = -xi;
         end
         OP_MOD: begin
            re = $signed(floor_sqrt(xr * xr + xi * xi));
         end
         default: ;
      endcase
      r.res_re = clamp_part(re, sat);
      r.res_im = clamp_part(im, sat);
      r.saturated = sat;
      return r;
   endfunction

   // cycle counter and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // response stall, with a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (long_hold > 0) begin
         rsp_chan.ready <= 1'b0;
         long_hold <= long_hold - 1;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // compare each accepted response word with the oldest expectation
   always @(posedge clock) begin
      cau_resp_type got;
      cau_resp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.res_re, rsp_chan.res_im, rsp_chan.div_zero, rsp_chan.saturated};
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response word re=%h im=%h", got.res_re, got.res_im);
         end else begin
            want = expected_words.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected re=%h im=%h dz=%b sat=%b, ",
                            "got re=%h im=%h dz=%b sat=%b"},
                           want.res_re, want.res_im, want.div_zero, want.saturated,
                           got.res_re, got.res_im, got.div_zero, got.saturated);
            end
         end
      end
   end

   // offer one request word and wait for it to be taken; valid stays high so
   // the next word can follow in the very next cycle
   task automatic send_request(input logic [2:0] op, input logic [31:0] ar,
                               input logic [31:0] ai, input logic [31:0] br,
                               input logic [31:0] bi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= op;
      req_chan.a_re     <= ar;
      req_chan.a_im     <= ai;
      req_chan.b_re     <= br;
      req_chan.b_im     <= bi;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_words.push_back(predict_complex(op, ar, ai, br, bi));
   endtask

   // operand mixing extremes, small values and full random bits
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '0;
         3, 4: return $urandom_range(2 ** 20) - 2 ** 19;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [2:0] pick_op();
      return ($urandom_range(49) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
   endfunction

   task automatic test_directed();
      logic [31:0] mx, mn;
      mx = 32'h7fff_ffff;
      mn = 32'h8000_0000;
      for (int k = 0; k <= 5; k++) send_request(3'(k), 32'h0001_8000, 32'hfffe_4000,
                                                32'h0000_c000, 32'h0002_0000);
      send_request(OP_ADD, mx, mn, mx, mn);
      send_request(OP_SUB, mn, mx, mx, mn);
      send_request(OP_MUL, mn, mn, mn, mx);
      send_request(OP_MUL, mx, mx, mx, mn);
      send_request(OP_DIV, 32'h0001_0000, 32'h0001_0000, '0, '0);
      send_request(OP_DIV, mn, mx, 32'd1, '0);
      send_request(OP_DIV, mx, mn, mn, mn);
      send_request(OP_DIV, 32'hffff_ffff, 32'd1, 32'd3, 32'hffff_fffd);
      send_request(OP_CONJ, mn, mn, '0, '0);
      send_request(OP_CONJ, mx, mx, '0, '0);
      send_request(OP_MOD, mn, mn, '0, '0);
      send_request(OP_MOD, 32'h0003_0000, 32'hfffc_0000, '0, '0);
      send_request(OP_MOD, '0, '0, '0, '0);
      send_request(OP_SPARE6, mx, mx, mx, mx);
      send_request(OP_SPARE7, mn, mn, mn, mn);
   endtask

   task automatic test_random(input int n_items, input int s_pct, input int r_pct);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      repeat (n_items) send_request(pick_op(), pick_operand(), pick_operand(),
                                    pick_operand(), pick_operand());
   endtask

   // response side stops for a long stretch while requests keep coming
   task automatic test_backpressure();
      send_idle_pct = 0;
      long_hold <= 300;
      repeat (30) send_request(3'($urandom_range(4)), pick_operand(), pick_operand(),
                               pick_operand(), pick_operand());
   endtask

   initial begin
      int drain;
      reset = 1'b1;
      cycle_count = 0;
      mismatches = 0;
      long_hold = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall.hold_rsp = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.req_type = '0;
      req_chan.a_re = '0;
      req_chan.a_im = '0;
      req_chan.b_re = '0;
      req_chan.b_im = '0;
      rsp_chan.ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(250, 22, 54);
      test_backpressure();
      test_random(250, 54, 22);
      test_random(250, 0, 0);
      req_chan.valid <= 1'b0;

      while (expected_words.size() != 0) @(posedge clock);
      drain = 0;
      while (drain < DRAIN_CYCLES) begin
         @(posedge clock);
         drain++;
      end
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[files.f]
rtl/cau_pkg.sv
rtl/cau_if.sv
rtl/cau_front.sv
rtl/cau_queue.sv
rtl/cau_back.sv
rtl/complex_arithmetic_unit.sv
sim/tb_cau_pkg.sv
sim/tb_cau_if.sv
sim/tb_complex_arithmetic_unit.sv
